// ----- hw/rtl/tcb_pkg.sv -----
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared constants and types for the text console buffer: default screen
// geometry, reset values of cells and attribute, and the command codes.
// ----------------------------------------------------------------------------
package tcb_pkg;

	// default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// cell and attribute reset values
	localparam logic [7:0]  TEXT_COLOR_RST = 8'h07;
	localparam logic [7:0]  BLANK_CHAR     = 8'h20;
	localparam logic [15:0] BLANK_CELL     = {TEXT_COLOR_RST, BLANK_CHAR};

	// command codes
	typedef enum logic [1:0] {
		MODE_PUT_CURSOR = 2'd0,
		MODE_PUT_POS    = 2'd1,
		MODE_CLEAR      = 2'd2,
		MODE_READ       = 2'd3
	} mode_t;

endpackage

// ----- hw/rtl/tcb_ram.sv -----
// ----------------------------------------------------------------------------
// tcb_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module tcb_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 2000,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/tcb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcb_ctrl
// Command sequencer of the text console buffer: decodes commands, keeps the
// cursor, drives the screen memory and walks it for clear, scroll and the
// clearing pass after reset.
// ----------------------------------------------------------------------------
module tcb_ctrl import tcb_pkg::*; #(
	parameter  int COLS  = COLS_DEF,
	parameter  int ROWS  = ROWS_DEF,
	localparam int CELLS = COLS * ROWS,
	localparam int AW    = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	// command side
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    mode,
	input  logic [7:0]    char_code,
	input  logic [7:0]    cell_color,
	input  logic [7:0]    column,
	input  logic [6:0]    row,
	input  logic [7:0]    text_color,
	// result side
	output logic          done,
	output logic [7:0]    cursor_col,
	output logic [6:0]    cursor_line,
	output logic [15:0]   cell_value,
	output logic          scrolled,
	output logic          bad_position,
	// screen memory
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam int COPY = COLS * (ROWS - 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_CP  = AW'(COPY - 1);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_CLEAR  = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_ZERO   = 6'b100000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   idx_q;
	logic [7:0]      cur_col_q;
	logic [6:0]      cur_row_q;
	logic            done_q;
	logic [15:0]     value_q;
	logic            scrolled_q;
	logic            bad_q;
	logic            cp_vld_s1;
	logic [AW-1:0]   cp_idx_s1;

	logic            accept;
	logic            in_bounds;
	logic [AW-1:0]   pos_addr;
	logic [AW-1:0]   cur_addr;
	logic [8:0]      col_inc;
	logic [7:0]      row_inc;
	logic            wrap;
	logic            last_row;

	// decode the command and cursor step
	assign accept    = start && (state_q == ST_IDLE);
	assign in_bounds = ({1'b0, column} < 9'(COLS)) && ({1'b0, row} < 8'(ROWS));
	assign pos_addr  = AW'(row) * AW'(COLS) + AW'(column);
	assign cur_addr  = AW'(cur_row_q) * AW'(COLS) + AW'(cur_col_q);
	assign col_inc   = {1'b0, cur_col_q} + 9'd1;
	assign row_inc   = {1'b0, cur_row_q} + 8'd1;
	assign wrap      = col_inc >= 9'(COLS);
	assign last_row  = row_inc >= 8'(ROWS);

	// drive the screen memory
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_raddr = pos_addr;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = BLANK_CELL;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = {text_color, BLANK_CHAR};
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (mode_t'(mode))
						MODE_PUT_CURSOR: begin
							mem_we    = 1'b1;
							mem_waddr = cur_addr;
							mem_wdata = {text_color, char_code};
						end
						MODE_PUT_POS: begin
							mem_we    = in_bounds;
							mem_waddr = pos_addr;
							mem_wdata = {cell_color, char_code};
						end
						MODE_CLEAR, MODE_READ: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCROLL: begin
				// read one row ahead, write back the word read last cycle
				mem_raddr = idx_q + AW'(COLS);
				if (cp_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cp_idx_s1;
					mem_wdata = mem_rdata;
				end
			end
			ST_ZERO: begin
				mem_we = 1'b1;
				if (cp_vld_s1) begin
					mem_waddr = cp_idx_s1;
					mem_wdata = mem_rdata;
				end
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// sequence commands, sweeps and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			idx_q      <= '0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			done_q     <= 1'b0;
			value_q    <= '0;
			scrolled_q <= 1'b0;
			bad_q      <= 1'b0;
			cp_vld_s1  <= 1'b0;
			cp_idx_s1  <= '0;
		end else begin
			done_q    <= 1'b0;
			cp_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						value_q    <= '0;
						scrolled_q <= 1'b0;
						bad_q      <= 1'b0;
						unique case (mode_t'(mode))
							MODE_PUT_CURSOR: begin
								if (wrap) begin
									cur_col_q <= '0;
									if (last_row) begin
										cur_row_q <= 7'(ROWS - 1);
										idx_q     <= '0;
										state_q   <= ST_SCROLL;
									end else begin
										cur_row_q <= row_inc[6:0];
										done_q    <= 1'b1;
									end
								end else begin
									cur_col_q <= col_inc[7:0];
									done_q    <= 1'b1;
								end
							end
							MODE_PUT_POS: begin
								bad_q  <= !in_bounds;
								done_q <= 1'b1;
							end
							MODE_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								idx_q     <= '0;
								state_q   <= ST_CLEAR;
							end
							MODE_READ: begin
								if (in_bounds) begin
									state_q <= ST_READ;
								end else begin
									bad_q  <= 1'b1;
									done_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					value_q <= mem_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					cp_vld_s1 <= 1'b1;
					cp_idx_s1 <= idx_q;
					idx_q     <= idx_q + AW'(1);
					if (idx_q == LAST_CP) begin
						state_q <= ST_ZERO;
					end
				end
				ST_ZERO: begin
					// hold the index while the last copied word drains
					if (!cp_vld_s1) begin
						idx_q <= idx_q + AW'(1);
						if (idx_q == LAST_IDX) begin
							idx_q      <= '0;
							scrolled_q <= 1'b1;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign cursor_col   = cur_col_q;
	assign cursor_line  = cur_row_q;
	assign cell_value   = value_q;
	assign scrolled     = scrolled_q;
	assign bad_position = bad_q;

	// a result is only given once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	// the cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_col_q} < 9'(COLS)) && ({1'b0, cur_row_q} < 8'(ROWS)))
		else $error("cursor off screen");

	// a scroll leaves the cursor at the start of the bottom row
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && scrolled_q) |-> (cur_col_q == '0) && (cur_row_q == 7'(ROWS - 1)))
		else $error("cursor misplaced after scroll");

	// a valid read command moves to the read state to wait for the memory word
	a_read_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_READ) && in_bounds) |=> (state_q == ST_READ))
		else $error("read command did not wait for memory");

	// a copied word is only pending during the scroll walk
	a_copy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> ((state_q == ST_SCROLL) || (state_q == ST_ZERO)))
		else $error("copy word pending outside scroll");

endmodule

// ----- hw/rtl/text_console_buffer.sv -----
// ----------------------------------------------------------------------------
// text_console_buffer
// Text screen of COLS x ROWS 16-bit cells (attribute high, character low)
// with a cursor, commands to write, clear, scroll and read back cells.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result word
// appears on the result ports for a single cycle with done high, and must be
// taken then, since the block cannot be stalled from the result side. A write
// at the cursor that does not scroll, a write at a position and an off-screen
// read give their result in the cycle after the command, and the next command
// can be taken in that same cycle. A read of a cell passes through a read
// state for the registered memory read. Clearing the screen and a write that
// scrolls walk every cell through the single write port of the screen memory.
// After reset the block runs a clearing pass over all COLS*ROWS cells (2000 at
// 80x25) with busy high; the text_color register can be written at any time
// that busy is low.
module text_console_buffer import tcb_pkg::*; #(
	parameter  int COLS = COLS_DEF,
	parameter  int ROWS = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [7:0]  char_code,
	input  logic [7:0]  cell_color,
	input  logic [7:0]  column,
	input  logic [6:0]  row,
	// result
	output logic        done,
	output logic [7:0]  cursor_col,
	output logic [6:0]  cursor_line,
	output logic [15:0] cell_value,
	output logic        scrolled,
	output logic        bad_position,
	// attribute register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]    text_color_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	// hold the attribute for cursor writes and clearing
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	tcb_ctrl #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.char_code    (char_code),
		.cell_color   (cell_color),
		.column       (column),
		.row          (row),
		.text_color   (text_color_q),
		.done         (done),
		.cursor_col   (cursor_col),
		.cursor_line  (cursor_line),
		.cell_value   (cell_value),
		.scrolled     (scrolled),
		.bad_position (bad_position),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	tcb_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
